// ===== hw/rtl/csfr_pkg.sv =====
// Shared types and constants for the CO2 sensor frame receiver.
package csfr_pkg;

  // Frame delimiters
  localparam logic [7:0] START_BYTE = 8'hFF;
  localparam logic [7:0] CMD_BYTE   = 8'h86;

  // Frame byte positions; position 0 means hunting for the start byte
  localparam logic [3:0] POS_HUNT   = 4'd0;
  localparam logic [3:0] POS_CMD    = 4'd1;
  localparam logic [3:0] POS_PPM_HI = 4'd2;
  localparam logic [3:0] POS_PPM_LO = 4'd3;
  localparam logic [3:0] POS_TEMP   = 4'd4;
  localparam logic [3:0] POS_LAST   = 4'd8;

  // Event codes reported with every result
  localparam logic [2:0] EV_HUNT   = 3'd0;
  localparam logic [2:0] EV_STORED = 3'd1;
  localparam logic [2:0] EV_GOOD   = 3'd2;
  localparam logic [2:0] EV_BAD    = 3'd3;
  localparam logic [2:0] EV_LINE   = 3'd4;
  localparam logic [2:0] EV_RESYNC = 3'd5;

  typedef struct packed {
    logic       req_type;
    logic [7:0] rx_byte;
    logic       rx_error;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  event_res;
    logic [15:0] ppm;
    logic [7:0]  temp_byte;
    logic        valid_seen;
    logic        error_seen;
    logic        frame_seen;
    logic        byte_seen;
  } out_item_t;

  typedef struct packed {
    logic byte_seen;
    logic frame_seen;
    logic error_seen;
    logic valid_seen;
  } flags_t;

  // Parser status visible to the top level
  typedef struct packed {
    logic [3:0] pos;
    flags_t     flags;
  } status_t;

endpackage

// ===== hw/rtl/csfr_in_reg.sv =====
// Input register stage of the CO2 sensor frame receiver.
module csfr_in_reg (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  csfr_pkg::in_item_t  in_data,
  input  logic                can_load,
  output logic                advance,
  output csfr_pkg::in_item_t  item
);
  import csfr_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  in_item_t data_r;

  assign advance  = valid_r && can_load;
  assign in_ready = !valid_r || advance;
  assign item     = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (in_ready) begin
      valid_nxt = in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      data_r <= in_data;
    end
  end

endmodule

// ===== hw/rtl/csfr_parser.sv =====
// Frame parser state and next-state logic of the CO2 sensor frame receiver.
module csfr_parser (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  csfr_pkg::in_item_t   item,
  output csfr_pkg::out_item_t  res,
  output csfr_pkg::status_t    stat
);
  import csfr_pkg::*;

  logic [3:0]  pos_r, pos_nxt;
  logic [7:0]  sum_r, sum_nxt;
  logic [15:0] ppm_cand_r, ppm_cand_nxt;
  logic [7:0]  temp_cand_r, temp_cand_nxt;
  logic [15:0] ppm_lat_r, ppm_lat_nxt;
  logic [7:0]  temp_lat_r, temp_lat_nxt;
  flags_t      flags_r, flags_nxt;
  logic [2:0]  ev;
  logic [7:0]  sum_neg;

  assign sum_neg = 8'd0 - sum_r;

  always_comb begin
    pos_nxt       = pos_r;
    sum_nxt       = sum_r;
    ppm_cand_nxt  = ppm_cand_r;
    temp_cand_nxt = temp_cand_r;
    ppm_lat_nxt   = ppm_lat_r;
    temp_lat_nxt  = temp_lat_r;
    flags_nxt     = flags_r;
    ev            = EV_HUNT;
    if (item.req_type) begin
      pos_nxt = POS_HUNT;
      ev      = EV_RESYNC;
    end else if (item.rx_error) begin
      // line error drops the partial frame; byte_seen untouched
      pos_nxt              = POS_HUNT;
      flags_nxt.error_seen = 1'b1;
      ev                   = EV_LINE;
    end else begin
      flags_nxt.byte_seen = 1'b1;
      if (pos_r == POS_HUNT) begin
        if (item.rx_byte == START_BYTE) begin
          sum_nxt = 8'd0;
          pos_nxt = POS_CMD;
          ev      = EV_STORED;
        end
      end else if (pos_r == POS_CMD) begin
        // a wrong command byte, even a start byte, returns to hunting
        if (item.rx_byte != CMD_BYTE) begin
          pos_nxt = POS_HUNT;
        end else begin
          sum_nxt = item.rx_byte;
          pos_nxt = POS_PPM_HI;
          ev      = EV_STORED;
        end
      end else if (pos_r < POS_LAST) begin
        if (pos_r == POS_PPM_HI) begin
          ppm_cand_nxt[15:8] = item.rx_byte;
        end else if (pos_r == POS_PPM_LO) begin
          ppm_cand_nxt[7:0] = item.rx_byte;
        end else if (pos_r == POS_TEMP) begin
          temp_cand_nxt = item.rx_byte;
        end
        sum_nxt = sum_r + item.rx_byte;
        pos_nxt = pos_r + 4'd1;
        ev      = EV_STORED;
      end else begin
        // checksum byte
        pos_nxt              = POS_HUNT;
        flags_nxt.frame_seen = 1'b1;
        if (sum_neg == item.rx_byte) begin
          ppm_lat_nxt          = ppm_cand_r;
          temp_lat_nxt         = temp_cand_r;
          flags_nxt.valid_seen = 1'b1;
          ev                   = EV_GOOD;
        end else begin
          flags_nxt.error_seen = 1'b1;
          ev                   = EV_BAD;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= POS_HUNT;
      sum_r       <= 8'd0;
      ppm_cand_r  <= 16'd0;
      temp_cand_r <= 8'd0;
      ppm_lat_r   <= 16'd0;
      temp_lat_r  <= 8'd0;
      flags_r     <= '0;
    end else if (step) begin
      pos_r       <= pos_nxt;
      sum_r       <= sum_nxt;
      ppm_cand_r  <= ppm_cand_nxt;
      temp_cand_r <= temp_cand_nxt;
      ppm_lat_r   <= ppm_lat_nxt;
      temp_lat_r  <= temp_lat_nxt;
      flags_r     <= flags_nxt;
    end
  end

  // results reflect the state after this transaction
  always_comb begin
    res.event_res  = ev;
    res.ppm        = ppm_lat_nxt;
    res.temp_byte  = temp_lat_nxt;
    res.valid_seen = flags_nxt.valid_seen;
    res.error_seen = flags_nxt.error_seen;
    res.frame_seen = flags_nxt.frame_seen;
    res.byte_seen  = flags_nxt.byte_seen;
  end

  assign stat.pos   = pos_r;
  assign stat.flags = flags_r;

endmodule

// ===== hw/rtl/csfr_out_reg.sv =====
// Result register of the CO2 sensor frame receiver.
module csfr_out_reg (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 load,
  input  csfr_pkg::out_item_t  res,
  output logic                 can_load,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csfr_pkg::out_item_t  out_data
);
  import csfr_pkg::*;

  logic      valid_r;
  logic      valid_nxt;
  out_item_t data_r;

  assign can_load  = !valid_r || out_ready;
  assign out_valid = valid_r;
  assign out_data  = data_r;

  always_comb begin
    valid_nxt = valid_r;
    if (load) begin
      valid_nxt = 1'b1;
    end else if (out_ready) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      data_r <= res;
    end
  end

endmodule

// ===== hw/rtl/co2_sensor_frame_receiver.sv =====
// Top level of the CO2 sensor frame receiver.
// Takes one UART byte transaction per cycle (data byte, line-error flag, or a
// resync request) and returns exactly one result transaction for each. The
// receiver hunts for 0xFF, then 0x86, collects the nine-byte frame and checks
// that the negated 8-bit sum of bytes 1 to 7 equals byte 8; a passing frame
// latches ppm (bytes 2,3 big-endian) and temp_byte (byte 4). Every result
// carries the event code, the last accepted readings and four sticky flags,
// all as they stand after that transaction. The input register holds each
// accepted transaction, and the parser logic loads its result into the result
// register when that register can take it. Sustained rate is one transaction
// per cycle; output backpressure stalls the input register, which still takes a
// new transaction in the cycle the result register drains.
module co2_sensor_frame_receiver (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  csfr_pkg::in_item_t   in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output csfr_pkg::out_item_t  out_data
);
  import csfr_pkg::*;

  logic      advance;
  logic      can_load;
  in_item_t  item;
  out_item_t res;
  status_t   stat;

  // input register: holds one transaction ahead of the parser
  csfr_in_reg u_in_reg (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .can_load (can_load),
    .advance  (advance),
    .item     (item)
  );

  // parser state moves only when its result goes into the result register
  csfr_parser u_parser (
    .clk   (clk),
    .rst_n (rst_n),
    .step  (advance),
    .item  (item),
    .res   (res),
    .stat  (stat)
  );

  csfr_out_reg u_out_reg (
    .clk       (clk),
    .rst_n     (rst_n),
    .load      (advance),
    .res       (res),
    .can_load  (can_load),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // frame position never runs past the checksum byte
  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    stat.pos <= POS_LAST)
    else $error("frame position out of range");

  // sticky flags never clear once set
  a_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) |-> ((stat.flags & $past(stat.flags)) == $past(stat.flags)))
    else $error("sticky flag cleared");

  // a good frame always reports valid and frame flags
  a_good_flags: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.event_res == EV_GOOD) |-> (res.valid_seen && res.frame_seen))
    else $error("good frame without valid/frame flags");

  // input stalls only while the input register is occupied and blocked
  a_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without output backpressure");

endmodule
